/* sv/fpba_pkg.sv */
// Shared types, widths and codes of the fit-policy block allocator.
// Depends on nothing; every other file of the block imports it.
package fpba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    // Fixed field widths of the request and response beats.
    localparam int OP_W     = 3;
    localparam int REQ_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CSIZE_W  = 16;
    localparam int POS_W    = 4;

    // Table index and fill count widths.
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_FIRST = 3'd2;
    localparam logic [OP_W-1:0] OP_BEST  = 3'd3;
    localparam logic [OP_W-1:0] OP_WORST = 3'd4;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // One table entry as stored in the block memory.
    typedef struct packed {
        logic                 free;
        logic [SIZE_BITS-1:0] size;
    } t_entry;

endpackage

/* sv/fpba_if.sv */
// Valid/ready channels of the fit-policy block allocator: request and response.
// Depends on fpba_pkg for the field widths.
interface fpba_req_if;
    import fpba_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [REQ_W-1:0]  request_size;

    modport source (output valid, output opcode, output request_size, input ready);
    modport sink   (input valid, input opcode, input request_size, output ready);
endinterface

interface fpba_rsp_if;
    import fpba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CSIZE_W-1:0]  chosen_size;
    logic [POS_W-1:0]    chosen_position;

    modport source (output valid, output status, output chosen_size,
                    output chosen_position, input ready);
    modport sink   (input valid, input status, input chosen_size,
                    input chosen_position, output ready);
endinterface

/* sv/fit_policy_block_allocator_top.sv */
// Fit-policy block allocator: a table of up to MAX_BLOCKS blocks (size plus
// free mark) held in one synchronous memory, entry 0 being the oldest block.
// Each request beat yields exactly one response beat. Init, and an add to a
// table that is not full, write the memory once. First, best and worst fit and
// free read the table from the newest entry down, one entry per cycle through
// the single read port, then write the chosen entry back; first fit and free
// stop at the first hit and a miss skips the write-back. Requests are taken
// one at a time; a finished response waits in the output register while the
// next request is already accepted, and a response that is still waiting
// holds the following one back. The table contents are undefined after reset
// and only the fill count and control state are cleared, so no clearing pass
// is needed.
module fit_policy_block_allocator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpba_req_if.sink   i_req,
    fpba_rsp_if.source o_rsp
);
    import fpba_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_data;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [OP_W-1:0]      r_op, n_op;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic [CNT_W-1:0]     r_left, n_left;
    logic                 r_eval, n_eval;
    logic [IDX_W-1:0]     r_eval_idx, n_eval_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_pick_size, n_pick_size;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [CSIZE_W-1:0]   r_out_size, n_out_size;
    logic [POS_W-1:0]     r_out_pos, n_out_pos;

    logic                 w_accept;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_entry               w_wdata;
    logic                 w_hit;
    logic                 w_better;
    logic                 w_stop;
    logic [WIDE_W-1:0]    w_pos_wide;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.chosen_size     = r_out_size;
    assign o_rsp.chosen_position = r_out_pos;

    // Position counted from the newest block.
    assign w_pos_wide = WIDE_W'(r_count) - WIDE_W'(r_pick) - WIDE_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_req       = r_req;
        n_addr      = r_addr;
        n_left      = r_left;
        n_eval      = r_eval;
        n_eval_idx  = r_eval_idx;
        n_found     = r_found;
        n_pick      = r_pick;
        n_pick_size = r_pick_size;
        n_status    = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_size   = r_out_size;
        n_out_pos    = r_out_pos;
        w_we        = 1'b0;
        w_waddr     = r_pick;
        w_wdata     = '{free: 1'b1, size: r_req};
        w_hit       = 1'b0;
        w_better    = 1'b0;
        w_stop      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op        = i_req.opcode;
                    n_req       = SIZE_BITS'(i_req.request_size);
                    n_status    = ST_DONE;
                    n_found     = 1'b0;
                    n_pick      = '0;
                    n_pick_size = '0;
                    n_eval      = 1'b0;
                    n_left      = r_count;
                    n_addr      = IDX_W'(r_count - CNT_W'(1));
                    n_state     = S_DONE;
                    w_wdata     = '{free: 1'b1, size: SIZE_BITS'(i_req.request_size)};
                    unique case (i_req.opcode)
                        OP_INIT: begin
                            w_we    = 1'b1;
                            w_waddr = '0;
                            n_count = CNT_W'(1);
                        end
                        OP_ADD: begin
                            if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = IDX_W'(r_count);
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_FIRST, OP_BEST, OP_WORST, OP_FREE: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Judge the entry read in the previous cycle.
                if (r_eval) begin
                    if (r_op == OP_FREE) begin
                        w_hit = !r_rd_data.free && (r_rd_data.size == r_req);
                    end else begin
                        w_hit = r_rd_data.free && (r_rd_data.size >= r_req);
                    end
                    w_better = !r_found
                        || ((r_op == OP_BEST) && (r_rd_data.size < r_pick_size))
                        || ((r_op == OP_WORST) && (r_rd_data.size > r_pick_size));
                    if (w_hit && w_better) begin
                        n_found     = 1'b1;
                        n_pick      = r_eval_idx;
                        n_pick_size = r_rd_data.size;
                    end
                    w_stop = w_hit && ((r_op == OP_FIRST) || (r_op == OP_FREE));
                end
                if (!w_stop && (r_left != '0)) begin
                    n_eval     = 1'b1;
                    n_eval_idx = r_addr;
                    n_addr     = r_addr - IDX_W'(1);
                    n_left     = r_left - CNT_W'(1);
                end else begin
                    n_eval = 1'b0;
                end
                if (w_stop || (r_left == '0)) begin
                    if (n_found) begin
                        n_state = S_WRITE;
                    end else begin
                        n_status = ST_NONE;
                        n_state  = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_pick;
                w_wdata = '{free: (r_op == OP_FREE), size: r_pick_size};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_size   = r_found ? CSIZE_W'(r_pick_size) : '0;
                    n_out_pos    = r_found ? w_pos_wide[POS_W-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    // Block memory; a write-back always lands before the next request's reads.
    // The entry addressed in this cycle is judged in the next one, beside its index.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_eval      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_eval      <= n_eval;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_req        <= n_req;
        r_addr       <= n_addr;
        r_left       <= n_left;
        r_eval_idx   <= n_eval_idx;
        r_pick       <= n_pick;
        r_pick_size  <= n_pick_size;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_size   <= n_out_size;
        r_out_pos    <= n_out_pos;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count exceeds table depth");

    a_full_add_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.opcode == OP_ADD) && (r_count == CNT_W'(MAX_BLOCKS)))
        |=> $stable(r_count))
        else $error("add on a full table changed the count");

    a_init_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.opcode == OP_INIT)) |=> (r_count == CNT_W'(1)))
        else $error("init did not leave one block");

    a_pick_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (CNT_W'(r_pick) < r_count))
        else $error("chosen entry lies beyond the filled table");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_DONE))
        |-> ((o_rsp.chosen_size == '0) && (o_rsp.chosen_position == '0)))
        else $error("failed request reports a block");
`endif

endmodule

/* bench/fpba_alloc_checker.sv */
// Scoreboard for the fit-policy block allocator: watches both channels, keeps its
// own copy of the block table and compares every response beat field by field.
// Depends on fpba_pkg and the channel interfaces in fpba_if.
`timescale 1ns / 1ps

module fpba_alloc_checker
    import fpba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fpba_req_if  i_req,
    fpba_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_answered,
    output int   o_grants,
    output int   o_misses,
    output int   o_fulls
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CSIZE_W-1:0]  size;
        logic [POS_W-1:0]    pos;
    } alloc_reply_t;

    alloc_reply_t reply_q[$];

    // Table copy: index 0 is the oldest block, blk_count - 1 the newest.
    logic [SIZE_BITS-1:0] blk_size [MAX_BLOCKS];
    logic                 blk_free [MAX_BLOCKS];
    int                   blk_count = 0;

    int fails    = 0;
    int answered = 0;
    int grants   = 0;
    int misses   = 0;
    int fulls    = 0;

    function automatic alloc_reply_t apply_request(input logic [OP_W-1:0] op,
                                                   input logic [REQ_W-1:0] req_sz);
        alloc_reply_t r;
        int slot;
        r    = '0;
        slot = -1;
        case (op)
            OP_INIT: begin
                blk_size[0] = req_sz;
                blk_free[0] = 1'b1;
                blk_count   = 1;
            end
            OP_ADD: begin
                if (blk_count >= MAX_BLOCKS) begin
                    r.status = ST_FULL;
                    fulls++;
                end else begin
                    blk_size[blk_count] = req_sz;
                    blk_free[blk_count] = 1'b1;
                    blk_count++;
                end
            end
            OP_FIRST, OP_BEST, OP_WORST: begin
                // Scan from the newest block; a strict compare keeps the newest on ties.
                for (int i = blk_count - 1; i >= 0; i--) begin
                    if (blk_free[i] && blk_size[i] >= req_sz) begin
                        if (slot < 0) begin
                            slot = i;
                        end else if (op == OP_BEST && blk_size[i] < blk_size[slot]) begin
                            slot = i;
                        end else if (op == OP_WORST && blk_size[i] > blk_size[slot]) begin
                            slot = i;
                        end
                        if (op == OP_FIRST) break;
                    end
                end
                if (slot >= 0) begin
                    blk_free[slot] = 1'b0;
                end else begin
                    r.status = ST_NONE;
                end
            end
            OP_FREE: begin
                for (int i = blk_count - 1; i >= 0; i--) begin
                    if (!blk_free[i] && blk_size[i] == req_sz) begin
                        slot = i;
                        break;
                    end
                end
                if (slot >= 0) begin
                    blk_free[slot] = 1'b1;
                end else begin
                    r.status = ST_NONE;
                end
            end
            default: begin
            end
        endcase
        if (slot >= 0) begin
            r.size = CSIZE_W'(blk_size[slot]);
            r.pos  = POS_W'(blk_count - 1 - slot);
            grants++;
        end else if (r.status == ST_NONE) begin
            misses++;
        end
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        fails++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        alloc_reply_t want;
        if (!i_rst_n) begin
            blk_count = 0;
        end else begin
            // Push before popping so a beat that arrives on the request edge is still matched.
            if (i_req.valid && i_req.ready) begin
                reply_q.push_back(apply_request(i_req.opcode, i_req.request_size));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                answered++;
                if (reply_q.size() == 0) begin
                    fails++;
                    $display("%0t ns: response beat with nothing expected, status %0h size %0h pos %0h",
                             $time, i_rsp.status, i_rsp.chosen_size, i_rsp.chosen_position);
                end else begin
                    want = reply_q.pop_front();
                    if (want.status !== i_rsp.status)
                        flag_field("status", want.status, i_rsp.status);
                    if (want.size !== i_rsp.chosen_size)
                        flag_field("chosen_size", want.size, i_rsp.chosen_size);
                    if (want.pos !== i_rsp.chosen_position)
                        flag_field("chosen_position", want.pos, i_rsp.chosen_position);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= reply_q.size();
        o_answered   <= answered;
        o_grants     <= grants;
        o_misses     <= misses;
        o_fulls      <= fulls;
    end

endmodule

/* bench/fit_policy_block_allocator_top_tb.sv */
// Testbench top for the fit-policy block allocator: clock, reset, request and
// response traffic under changing idle mixes, and the final verdict.
// Depends on fpba_pkg, fpba_if, the block itself and fpba_alloc_checker.
`timescale 1ns / 1ps

module fit_policy_block_allocator_top_tb;
    import fpba_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_REQUESTS = 1550;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;

    // Opcodes the block leaves unused.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int beats_sent     = 0;
    int spare_ops      = 0;

    int fail_count, pending, answered, grants, misses, fulls;

    // Small pool of sizes so that frees find matches and fits hit ties.
    logic [REQ_W-1:0] size_pool [8] = '{16'h0000, 16'h0001, 16'h0010, 16'h0011,
                                        16'h0100, 16'h7fff, 16'h8000, 16'hffff};

    fpba_req_if req_ch ();
    fpba_rsp_if rsp_ch ();

    fit_policy_block_allocator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    fpba_alloc_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_answered   (answered),
        .o_grants     (grants),
        .o_misses     (misses),
        .o_fulls      (fulls)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [REQ_W-1:0] pick_size();
        if ($urandom_range(0, 99) < 80) return size_pool[$urandom_range(0, 7)];
        return REQ_W'($urandom_range(0, 65535));
    endfunction

    // Called on the edge that ended the previous beat; valid stays high when no gap is drawn.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req_sz);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.request_size <= req_sz;
        do @(posedge i_clk); while (!req_ch.ready);
        beats_sent++;
    endtask

    // Response side: random stalls, plus a long hold-off on request so the block backs up.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_request) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    initial begin
        int done;
        int roll;
        logic [OP_W-1:0] op;

        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_INIT;
        req_ch.request_size <= '0;
        i_rst_n             <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: fits and free find nothing.
        send_item(OP_FIRST, 16'h0000);
        send_item(OP_FREE, 16'h0000);
        // Fill to the limit with repeating sizes, then one add too many.
        send_item(OP_INIT, 16'hffff);
        for (int i = 1; i < MAX_BLOCKS; i++) send_item(OP_ADD, REQ_W'((i % 4) * 16'h5555));
        send_item(OP_ADD, 16'h1234);
        send_item(OP_BEST, 16'h1000);
        send_item(OP_WORST, 16'h0000);
        send_item(OP_FIRST, 16'hffff);
        send_item(OP_FREE, 16'h5555);
        send_item(OP_FREE, 16'h1234);
        send_item(OP_SPARE_LO, 16'hffff);
        send_item(OP_SPARE_HI, 16'h0000);

        done = 0;
        while (done < RANDOM_REQUESTS) begin
            case ((done / 100) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3)       op = OP_INIT;
            else if (roll < 33) op = OP_ADD;
            else if (roll < 47) op = OP_FIRST;
            else if (roll < 60) op = OP_BEST;
            else if (roll < 73) op = OP_WORST;
            else if (roll < 95) op = OP_FREE;
            else                op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            send_item(op, pick_size());
            if (op == OP_SPARE_LO || op == OP_SPARE_HI) begin
                spare_ops++;
            end else begin
                done++;
                if (done == 250 || done == 900) hold_request = 1'b1;
            end
        end
        req_ch.valid   <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // One edge so the checker's count includes the last request beat.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d request beats (%0d with unused opcodes) over four idle mixes and two long response hold-offs.",
                 beats_sent, spare_ops);
        $display("Checked %0d responses: %0d blocks taken or released, %0d misses, %0d adds refused on a full table.",
                 answered, grants, misses, fulls);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* fit_policy_block_allocator_top.f */
sv/fpba_pkg.sv
sv/fpba_if.sv
sv/fit_policy_block_allocator_top.sv
bench/fpba_alloc_checker.sv
bench/fit_policy_block_allocator_top_tb.sv
